// File: sv/saot_pkg.sv
// package for the stepped auto-off timer
// holds request and result types, operation codes and the step duration table
// no dependencies
`default_nettype none

package saot_pkg;

  localparam int unsigned SEC_W    = 21;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned TVAL_W   = 10;
  localparam int unsigned SPU_W    = 12;
  localparam int unsigned TPS_W    = 16;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET     = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic CFG_SPU = 1'b0;
  localparam logic CFG_TPS = 1'b1;

  typedef struct packed {
    op_t               operation;
    logic [STEP_W-1:0] step_value;
    logic              power_on;
  } req_t;

  typedef struct packed {
    logic [STEP_W-1:0] current_step;
    logic [SEC_W-1:0]  remaining_seconds;
    logic [TVAL_W-1:0] step_table_value;
    logic              auto_off;
  } res_t;

  function automatic logic [TVAL_W-1:0] step_dur(input logic [STEP_W-1:0] s);
    logic [TVAL_W-1:0] v;
    case (s)
      4'd0:    v = 10'd0;
      4'd1:    v = 10'd15;
      4'd2:    v = 10'd30;
      4'd3:    v = 10'd45;
      4'd4:    v = 10'd60;
      4'd5:    v = 10'd120;
      4'd6:    v = 10'd180;
      4'd7:    v = 10'd240;
      4'd8:    v = 10'd300;
      4'd9:    v = 10'd360;
      4'd10:   v = 10'd420;
      4'd11:   v = 10'd480;
      default: v = 10'd540;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: sv/saot_in_reg.sv
// input register of the stepped auto-off timer
// captures one request per cycle when not stalled; depends on saot_pkg
`default_nettype none

module saot_in_reg
  import saot_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic [IN_TUSER_W-1:0] in_tuser,
  input  wire logic                  adv,
  output logic                       req_valid,
  output req_t                       req
);

  logic vld_r;
  logic vld_nxt;
  req_t req_r;

  assign in_tready = !vld_r || adv;

  always_comb begin
    vld_nxt = vld_r;
    if (in_tready) begin
      vld_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r.operation  <= op_t'(in_tuser[1:0]);
      req_r.step_value <= in_tdata[3:0];
      req_r.power_on   <= in_tdata[4];
    end
  end

  assign req_valid = vld_r;
  assign req       = req_r;

endmodule

`default_nettype wire

// File: sv/saot_core.sv
// timer state and per-request update of the stepped auto-off timer
// holds configuration and countdown state; depends on saot_pkg
`default_nettype none

module saot_core
  import saot_pkg::*;
#(
  parameter int STEP_COUNT = 13
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_index,
  input  wire logic [TPS_W-1:0]  cfg_data,
  input  wire logic              req_valid,
  input  wire req_t              req,
  input  wire logic              adv,
  output res_t                   res
);

  logic [SPU_W-1:0]  spu_r, spu_nxt;
  logic [TPS_W-1:0]  tps_r, tps_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [STEP_W-1:0] lstep_r, lstep_nxt;
  logic [SEC_W-1:0]  rem_r, rem_nxt;
  logic [SEC_W-1:0]  total_r, total_nxt;
  logic [TPS_W-1:0]  tis_r, tis_nxt;
  logic [SEC_W-1:0]  ela_r, ela_nxt;
  logic [TVAL_W-1:0] lval_r, lval_nxt;

  logic              fire;
  logic              in_range;
  logic              reload;
  logic [STEP_W-1:0] step_dn;
  logic [STEP_W-1:0] step_adv;
  logic [STEP_W-1:0] mul_sel;
  logic [SEC_W:0]    prod;
  logic [SEC_W-1:0]  level;
  logic [TPS_W-1:0]  tick_inc;
  logic              second;
  logic [SEC_W-1:0]  ela_inc;
  logic [SEC_W-1:0]  rem_sec;
  logic              pulse;

  assign fire     = req_valid && adv;
  assign in_range = {1'b0, step_r} < 5'(STEP_COUNT);
  assign reload   = lstep_r != step_r;
  assign step_dn  = step_r - 4'd1;
  assign mul_sel  = reload ? step_r : step_dn;
  assign prod     = (SEC_W+1)'(step_dur(mul_sel)) * (SEC_W+1)'(spu_r);
  assign level    = prod[SEC_W] ? SEC_MAX : prod[SEC_W-1:0];
  assign tick_inc = tis_r + 16'd1;
  assign second   = tick_inc >= tps_r;
  assign ela_inc  = (ela_r != SEC_MAX) ? ela_r + 21'd1 : ela_r;
  assign rem_sec  = (total_r > ela_inc) ? total_r - ela_inc : '0;

  // advance with wrap, one constant entry per step
  always_comb begin
    step_adv = '0;
    for (int i = 0; i < 16; i++) begin
      if (step_r == STEP_W'(i)) begin
        step_adv = STEP_W'((i + 1) % STEP_COUNT);
      end
    end
  end

  always_comb begin
    spu_nxt = spu_r;
    tps_nxt = tps_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SPU: spu_nxt = cfg_data[SPU_W-1:0];
        CFG_TPS: tps_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    step_nxt  = step_r;
    lstep_nxt = lstep_r;
    rem_nxt   = rem_r;
    total_nxt = total_r;
    tis_nxt   = tis_r;
    ela_nxt   = ela_r;
    lval_nxt  = lval_r;
    pulse     = 1'b0;
    case (req.operation)
      OP_SET: begin
        step_nxt = req.step_value;
        if (req.step_value == '0) begin
          rem_nxt = '0;
        end
      end
      OP_ADVANCE: begin
        step_nxt = step_adv;
        if (step_adv == '0) begin
          rem_nxt = '0;
        end
      end
      OP_TICK: begin
        if (in_range) begin
          if (reload) begin
            lstep_nxt = step_r;
            lval_nxt  = step_dur(step_r);
            rem_nxt   = level;
            total_nxt = level;
            tis_nxt   = '0;
            ela_nxt   = '0;
          end
          if (step_r != '0) begin
            if (!reload) begin
              tis_nxt = tick_inc;
              if (second) begin
                tis_nxt = '0;
                ela_nxt = ela_inc;
                rem_nxt = rem_sec;
                if (rem_sec <= level) begin
                  step_nxt = step_dn;
                end
                if (rem_sec == '0) begin
                  pulse = 1'b1;
                end
              end
            end
          end else begin
            rem_nxt = '0;
          end
          if (!req.power_on) begin
            step_nxt = '0;
            rem_nxt  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spu_r   <= 12'd60;
      tps_r   <= 16'd1000;
      step_r  <= '0;
      lstep_r <= '0;
      rem_r   <= '0;
      total_r <= '0;
      tis_r   <= '0;
      ela_r   <= '0;
      lval_r  <= '0;
    end else begin
      spu_r <= spu_nxt;
      tps_r <= tps_nxt;
      if (fire) begin
        step_r  <= step_nxt;
        lstep_r <= lstep_nxt;
        rem_r   <= rem_nxt;
        total_r <= total_nxt;
        tis_r   <= tis_nxt;
        ela_r   <= ela_nxt;
        lval_r  <= lval_nxt;
      end
    end
  end

  assign res.current_step      = step_nxt;
  assign res.remaining_seconds = rem_nxt;
  assign res.step_table_value  = lval_nxt;
  assign res.auto_off          = pulse;

endmodule

`default_nettype wire

// File: sv/saot_out_reg.sv
// result register of the stepped auto-off timer
// packs one result per request onto the output stream; depends on saot_pkg
`default_nettype none

module saot_out_reg
  import saot_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   res_valid,
  input  wire res_t                   res,
  output logic                        adv,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  logic                   vld_r;
  logic [OUT_TDATA_W-1:0] data_r;

  assign adv = !vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      data_r <= {4'd0, res.auto_off, res.step_table_value,
                 res.remaining_seconds, res.current_step};
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;

endmodule

`default_nettype wire

// File: sv/stepped_auto_off_timer.sv
// top level of the stepped auto-off timer
// joins input register, timer core and result register; depends on saot_pkg
//
//   port group  direction  carries
//   in_*        in         one request: tick, set step or advance step
//   out_*       out        one result per request
//   cfg_*       in         register writes: 0 seconds per unit, 1 ticks per second
//
// a request passes the input, then the result register; one per cycle unless stalled
// the timer state updates in one pass as a request moves into the result register
// reset clears the countdown state and loads 60 s per unit and 1000 ticks per second
// a stalled result holds the core; the input register still takes one request
`default_nettype none

module stepped_auto_off_timer
  import saot_pkg::*;
#(
  parameter int STEP_COUNT = 13
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // step_value[3:0], power_on[4], zeros
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,   // operation[1:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // current_step[3:0],
                                                  // remaining_seconds[24:4],
                                                  // step_table_value[34:25],
                                                  // auto_off[35], zeros
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_index,
  input  wire logic [TPS_W-1:0]       cfg_data
);

  logic req_valid;
  req_t req;
  logic adv;
  res_t res;

  assign cfg_ready = 1'b1;

  saot_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .adv       (adv),
    .req_valid (req_valid),
    .req       (req)
  );

  saot_core #(
    .STEP_COUNT (STEP_COUNT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req       (req),
    .adv       (adv),
    .res       (res)
  );

  saot_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (req_valid),
    .res        (res),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
